>>> hdl/apms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apms_pkg: shared types and constants of the ARX plant model step core
// Controller states, controller/datapath command and status bundles,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package apms_pkg;

  localparam int DEF_MAX_ORDER     = 4;
  localparam int DEF_MAX_DEAD_TIME = 15;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_NUM   = 4;
  localparam int FRAC_B     = 12;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_MODEL_ORDER   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEAD_TIME     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LIMITS_ENABLE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IN_LIMITS     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_LIMITS    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_A_COEFS       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_B_COEFS       = 3'd6;

  // +10.0 high, -10.0 low in Q5.11
  localparam logic [31:0] RST_LIMIT_PAIR = 32'h5000_B000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MUL_B,
    ST_MUL_A,
    ST_FLUSH,
    ST_ROUND,
    ST_OUT
  } apms_state_e;

  typedef struct packed {
    logic load;      // take the input transfer, clear the tap index
    logic push;      // write input history, seed the accumulator
    logic rd_en;     // read one input history tap
    logic rd_next;   // read the tap of the next index
    logic mul_en;    // form one product
    logic mul_sel_a; // feedback product (subtracted) instead of input product
    logic idx_inc;   // advance the tap index
    logic round;     // round and saturate the accumulator
    logic out_load;  // clamp, push output history, load output register
  } apms_cmd_t;

  typedef struct packed {
    logic last;      // tap index is the last one in use
    logic out_free;  // output register can take a new result
  } apms_sts_t;

  function automatic logic signed [COEF_W-1:0] coef_sel(input logic [63:0] pk,
                                                         input logic [3:0]  i);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (i < 4'(COEF_NUM)) begin
      c = pk[i[1:0]*COEF_W +: COEF_W];
    end
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_pair(
    input logic signed [SAMPLE_W-1:0] v,
    input logic [31:0]                pair,
    input logic                       en
  );
    logic signed [SAMPLE_W-1:0] hi;
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] r;
    hi = pair[31:16];
    lo = pair[15:0];
    r  = v;
    if (en) begin
      if (r > hi) r = hi;
      if (r < lo) r = lo;
    end
    return r;
  endfunction

endpackage

>>> hdl/arx_plant_model_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arx_plant_model_step_core: ARX plant model, one output sample per input
// One input transfer (plant input u and a noise sample, Q5.11) produces one
// output transfer (plant output y, Q5.11). Coefficients are Q4.12.
//
// Usage:
//   - Slave stream carries {noise_sample, input_sample}; master stream
//     carries output_sample. Configuration is a write-only register port,
//     written while the core is idle.
//   - An accepted input passes through the history push, one input and one
//     feedback product per tap on the single shared multiplier, a flush,
//     rounding and the output load; a new input is taken only once the
//     sequencer has returned to idle.
//   - s_axis_tready is high only while the sequencer is idle.
//   - The result waits in the output register while m_axis_tready is low;
//     the sequencer holds in its final step until that register drains.
//   - Reset restores the register defaults and empties both histories:
//     unwritten history entries read as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
module arx_plant_model_step_core #(
  parameter int MAX_ORDER     = apms_pkg::DEF_MAX_ORDER,
  parameter int MAX_DEAD_TIME = apms_pkg::DEF_MAX_DEAD_TIME
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [apms_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [apms_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] input_sample, [31:16] noise_sample
  input  logic [apms_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [15:0] output_sample
  output logic [apms_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

  apms_pkg::apms_cmd_t cmd;
  apms_pkg::apms_sts_t sts;
  logic signed [apms_pkg::SAMPLE_W-1:0] out_sample;

  apms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  apms_dp #(
    .MAX_ORDER     (MAX_ORDER),
    .MAX_DEAD_TIME (MAX_DEAD_TIME)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_sample_i    (s_axis_tdata[15:0]),
    .noise_sample_i (s_axis_tdata[31:16]),
    .out_sample_o   (out_sample),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  assign m_axis_tdata = out_sample;

endmodule

>>> hdl/apms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apms_ctrl: sequencer of the ARX plant model step core
// Steps one sample through history push, alternating input and feedback
// products on the shared multiplier, rounding and output load.
// ----------------------------------------------------------------------------
module apms_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  apms_pkg::apms_sts_t sts_i,
  output apms_pkg::apms_cmd_t cmd_o
);

  apms_pkg::apms_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      apms_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = apms_pkg::ST_PUSH;
        end
      end
      apms_pkg::ST_PUSH: begin
        cmd_o.push  = 1'b1;
        cmd_o.rd_en = 1'b1;
        state_d     = apms_pkg::ST_MUL_B;
      end
      apms_pkg::ST_MUL_B: begin
        cmd_o.mul_en = 1'b1;
        state_d      = apms_pkg::ST_MUL_A;
      end
      apms_pkg::ST_MUL_A: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel_a = 1'b1;
        // prefetch the next tap while this feedback product forms
        cmd_o.rd_en     = !sts_i.last;
        cmd_o.rd_next   = 1'b1;
        cmd_o.idx_inc   = !sts_i.last;
        state_d         = sts_i.last ? apms_pkg::ST_FLUSH : apms_pkg::ST_MUL_B;
      end
      apms_pkg::ST_FLUSH: begin
        state_d = apms_pkg::ST_ROUND;
      end
      apms_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = apms_pkg::ST_OUT;
      end
      apms_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = apms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = apms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/apms_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apms_dp: datapath of the ARX plant model step core
// Configuration registers, circular input history memory, output history,
// shared multiply-accumulate, rounding, saturation, clamps, output register.
// ----------------------------------------------------------------------------
module apms_dp #(
  parameter int MAX_ORDER     = apms_pkg::DEF_MAX_ORDER,
  parameter int MAX_DEAD_TIME = apms_pkg::DEF_MAX_DEAD_TIME
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [apms_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [apms_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [apms_pkg::SAMPLE_W-1:0]  in_sample_i,
  input  logic signed [apms_pkg::SAMPLE_W-1:0]  noise_sample_i,
  output logic signed [apms_pkg::SAMPLE_W-1:0]  out_sample_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  input  apms_pkg::apms_cmd_t                   cmd_i,
  output apms_pkg::apms_sts_t                   sts_o
);

  localparam int SW     = apms_pkg::SAMPLE_W;
  localparam int DEPTH  = MAX_ORDER + MAX_DEAD_TIME;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW     = $clog2(DEPTH + 1);
  localparam int IW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ACC_W  = apms_pkg::PROD_W + $clog2(2 * MAX_ORDER + 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (SW - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (apms_pkg::FRAC_B - 1));

  // configuration
  logic [2:0]  model_order_q;
  logic [3:0]  dead_time_q;
  logic        limits_en_q;
  logic [31:0] in_lim_q;
  logic [31:0] out_lim_q;
  logic [63:0] a_coefs_q;
  logic [63:0] b_coefs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_order_q <= 3'd1;
      dead_time_q   <= 4'd1;
      limits_en_q   <= 1'b1;
      in_lim_q      <= apms_pkg::RST_LIMIT_PAIR;
      out_lim_q     <= apms_pkg::RST_LIMIT_PAIR;
      a_coefs_q     <= '0;
      b_coefs_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        apms_pkg::REG_MODEL_ORDER:   model_order_q <= cfg_wdata_i[2:0];
        apms_pkg::REG_DEAD_TIME:     dead_time_q   <= cfg_wdata_i[3:0];
        apms_pkg::REG_LIMITS_ENABLE: limits_en_q   <= cfg_wdata_i[0];
        apms_pkg::REG_IN_LIMITS:     in_lim_q      <= cfg_wdata_i[31:0];
        apms_pkg::REG_OUT_LIMITS:    out_lim_q     <= cfg_wdata_i[31:0];
        apms_pkg::REG_A_COEFS:       a_coefs_q     <= cfg_wdata_i;
        apms_pkg::REG_B_COEFS:       b_coefs_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // saturate order and dead time into their legal ranges
  logic [31:0] ord_w, dt_w, ord_sat, dt_sat;
  logic [IW-1:0] ord_m1;

  always_comb begin
    ord_w = {29'd0, model_order_q};
    dt_w  = {28'd0, dead_time_q};
    if (ord_w == 32'd0) ord_sat = 32'd1;
    else if (ord_w > 32'(MAX_ORDER)) ord_sat = 32'(MAX_ORDER);
    else ord_sat = ord_w;
    if (dt_w == 32'd0) dt_sat = 32'd1;
    else if (dt_w > 32'(MAX_DEAD_TIME)) dt_sat = 32'(MAX_DEAD_TIME);
    else dt_sat = dt_w;
    ord_m1 = IW'(ord_sat - 32'd1);
  end

  // sample registers, history pointer and fill count
  logic signed [SW-1:0] u_q, noise_q;
  logic [AW-1:0]        wptr_q;
  logic [FW-1:0]        fill_q;
  logic [IW-1:0]        idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      u_q     <= apms_pkg::clamp_pair(in_sample_i, in_lim_q, limits_en_q);
      noise_q <= noise_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
        if (fill_q != FW'(DEPTH)) fill_q <= fill_q + FW'(1);
        idx_q  <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  assign sts_o.last = (idx_q == ord_m1);

  // input history: circular buffer, newest entry at wptr_q
  logic signed [SW-1:0] hist_mem [DEPTH];
  logic [AW-1:0]        tap_d;
  logic [AW:0]          diff;
  logic [AW-1:0]        rd_addr;
  logic signed [SW-1:0] rd_q;
  logic                 rd_vld_q;

  always_comb begin
    tap_d   = AW'(dt_sat) + AW'(idx_q) + AW'(cmd_i.rd_next);
    diff    = {1'b0, wptr_q} - {1'b0, tap_d};
    rd_addr = diff[AW] ? AW'(diff + (AW + 1)'(DEPTH)) : diff[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_mem[wptr_q] <= u_q;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= hist_mem[rd_addr];
      // entries never pushed read as zero
      rd_vld_q <= (FW'(tap_d) < fill_q);
    end
  end

  // output history
  logic signed [SW-1:0] yhist_q [MAX_ORDER];

  // shared multiplier and accumulator
  logic signed [apms_pkg::COEF_W-1:0] mul_c;
  logic signed [SW-1:0]               mul_x;
  logic signed [apms_pkg::PROD_W-1:0] prod_q;
  logic                               prod_vld_q;
  logic                               prod_sub_q;
  logic signed [ACC_W-1:0]            acc_q;

  always_comb begin
    if (cmd_i.mul_sel_a) begin
      mul_c = apms_pkg::coef_sel(a_coefs_q, 4'(idx_q));
      mul_x = yhist_q[idx_q];
    end else begin
      mul_c = apms_pkg::coef_sel(b_coefs_q, 4'(idx_q));
      mul_x = rd_vld_q ? rd_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q     <= mul_c * mul_x;
      prod_sub_q <= cmd_i.mul_sel_a;
    end
    if (cmd_i.push) begin
      acc_q <= ACC_W'(noise_q) <<< apms_pkg::FRAC_B;
    end else if (prod_vld_q) begin
      acc_q <= prod_sub_q ? acc_q - ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mul_en;
    end
  end

  // round half up, then saturate to the sample width
  logic signed [ACC_W-1:0] rnd_t;
  logic signed [ACC_W-1:0] rnd_r;
  logic signed [SW-1:0]    sat_d, sat_q;

  always_comb begin
    rnd_t = acc_q + RND_HALF;
    rnd_r = rnd_t >>> apms_pkg::FRAC_B;
    if (rnd_r > SAT_MAX) sat_d = SW'(SAT_MAX);
    else if (rnd_r < SAT_MIN) sat_d = SW'(SAT_MIN);
    else sat_d = SW'(rnd_r);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      sat_q <= sat_d;
    end
  end

  // output clamp, history push and output register
  logic signed [SW-1:0] y_d;
  logic signed [SW-1:0] out_q;
  logic                 out_vld_q;

  assign y_d = apms_pkg::clamp_pair(sat_q, out_lim_q, limits_en_q);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        yhist_q[i] <= '0;
      end
    end else begin
      if (cmd_i.out_load) begin
        out_vld_q  <= 1'b1;
        yhist_q[0] <= y_d;
        for (int i = 1; i < MAX_ORDER; i++) begin
          yhist_q[i] <= yhist_q[i-1];
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= y_d;
    end
  end

  assign out_sample_o = out_q;
  assign out_valid_o  = out_vld_q;

endmodule
